@@ rtl/ccsc_pkg.sv @@
// Shared constants, codes and types of the charge configuration stability checker.
`timescale 1ns / 1ps

package ccsc_pkg;

   // Sizing
   localparam int MAX_SITES  = 32;
   localparam int FRAC_BITS  = 24;
   localparam int SITE_W     = $clog2(MAX_SITES);
   localparam int CNT_W      = $clog2(MAX_SITES + 1);
   localparam int PT_DEPTH   = MAX_SITES * MAX_SITES;
   localparam int PT_AW      = 2 * SITE_W;

   // Field widths
   localparam int IDX_FLD_W  = 5;
   localparam int CNT_FLD_W  = 6;
   localparam int POT_W      = 28;
   localparam int CHG_W      = 2;
   localparam int MU_W       = 29;
   localparam int TOL_W      = 16;
   localparam int LP_W       = 38;
   localparam int ENERGY_W   = 41;
   localparam int ESUM_W     = ENERGY_W + 1;
   localparam int CMP_W      = 40;
   localparam int CSR_AW     = 4;
   localparam int CSR_DW     = 32;

   // Reset values of the configuration registers (round to nearest)
   localparam longint MU_MINUS_RST_L = -(((longint'(32) << FRAC_BITS) + 50) / 100);
   localparam longint MU_PLUS_RST_L  = -(((longint'(91) << FRAC_BITS) + 50) / 100);
   localparam longint TOL_RST_L      = ((longint'(1) << FRAC_BITS) + 500000) / 1000000;
   localparam logic [CNT_FLD_W-1:0] SITE_COUNT_RST = CNT_FLD_W'(32);
   localparam logic [MU_W-1:0]      MU_MINUS_RST   = MU_W'(MU_MINUS_RST_L);
   localparam logic [MU_W-1:0]      MU_PLUS_RST    = MU_W'(MU_PLUS_RST_L);
   localparam logic [TOL_W-1:0]     TOL_RST        = TOL_W'(TOL_RST_L);

   // Request kinds
   localparam logic [1:0] REQ_WR_POT = 2'd0;
   localparam logic [1:0] REQ_WR_CHG = 2'd1;
   localparam logic [1:0] REQ_EVAL   = 2'd2;

   // Failure kinds
   localparam logic [1:0] FAIL_NONE = 2'd0;
   localparam logic [1:0] FAIL_SITE = 2'd1;
   localparam logic [1:0] FAIL_HOP  = 2'd2;

   // Charge codes
   localparam logic signed [CHG_W-1:0] CHG_NEG  = 2'sb11;
   localparam logic signed [CHG_W-1:0] CHG_ZERO = 2'sb00;
   localparam logic signed [CHG_W-1:0] CHG_POS  = 2'sb01;
   localparam logic        [CHG_W-1:0] CHG_BAD  = 2'b10;

   // Register indexes
   localparam logic [1:0] REG_SITE_COUNT = 2'd0;
   localparam logic [1:0] REG_MU_MINUS   = 2'd1;
   localparam logic [1:0] REG_MU_PLUS    = 2'd2;
   localparam logic [1:0] REG_TOLERANCE  = 2'd3;

   typedef struct packed {
      logic [CNT_FLD_W-1:0]   site_count;
      logic signed [MU_W-1:0] mu_minus;
      logic signed [MU_W-1:0] mu_plus;
      logic [TOL_W-1:0]       tolerance;
   } cfg_type;

   typedef struct packed {
      logic [1:0]                 fail_kind;
      logic [IDX_FLD_W-1:0]       bad_site;
      logic signed [ENERGY_W-1:0] energy;
   } result_type;

endpackage

@@ rtl/ccsc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module ccsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ccsc_engine.sv @@
// Sequencer and datapath: table loads, local potentials, site and hop checks, energy.
`timescale 1ns / 1ps

module ccsc_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ccsc_pkg::cfg_type                     cfg,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_kind,
   input  logic [ccsc_pkg::IDX_FLD_W-1:0]        site_a,
   input  logic [ccsc_pkg::IDX_FLD_W-1:0]        site_b,
   input  logic [ccsc_pkg::POT_W-1:0]            potential,
   input  logic signed [ccsc_pkg::CHG_W-1:0]     charge,
   output logic                                  res_valid,
   input  logic                                  res_ready,
   output ccsc_pkg::result_type                  res
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_LOCAL = 7'b0000010,
      ST_SITE  = 7'b0000100,
      ST_HSRC  = 7'b0001000,
      ST_HLOAD = 7'b0010000,
      ST_HOP   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   localparam int SW = ccsc_pkg::SITE_W;
   localparam int NW = ccsc_pkg::CNT_W;
   localparam int LW = ccsc_pkg::LP_W;
   localparam int CW = ccsc_pkg::CMP_W;
   localparam int EW = ccsc_pkg::ESUM_W;

   state_type state_ff, state_in;
   logic [NW-1:0] n_ff, n_in, n_eval;
   logic [SW-1:0] row_ff, row_in, col_ff, col_in;
   logic issue_ff, issue_in;
   logic s1_vld_ff, s1_vld_in, s1_first_ff, s1_first_in;
   logic s1_last_ff, s1_last_in, s1_final_ff, s1_final_in;
   logic [SW-1:0] s1_row_ff, s1_row_in, s1_idx_ff, s1_idx_in;
   logic signed [ccsc_pkg::CHG_W-1:0] s1_chg_ff, s1_chg_in, ci_ff, ci_in;
   logic signed [LW-1:0] acc_ff, acc_in, vi_ff, vi_in;
   logic signed [EW-1:0] esum_ff, esum_in;
   logic [1:0] kind_ff, kind_in;
   logic [SW-1:0] bad_ff, bad_in;

   logic signed [ccsc_pkg::CHG_W-1:0] chg_ff [ccsc_pkg::MAX_SITES];
   logic chg_we;

   logic pt_we;
   logic [ccsc_pkg::PT_AW-1:0] pt_waddr, pt_raddr;
   logic [ccsc_pkg::POT_W-1:0] pt_rdata;
   logic lp_we;
   logic [SW-1:0] lp_waddr, lp_raddr;
   logic [LW-1:0] lp_wdata, lp_rdata;

   logic row_last, col_last, a_ok, b_ok;
   logic signed [ccsc_pkg::CHG_W-1:0] chg_col, chg_row;
   logic signed [LW-1:0] lp_v, pot_x, pot_term, lp_sum;
   logic signed [CW-1:0] v_x, vi_x, p_x, mum_x, mup_x, tol_x, ntol_x, dm, dp, hop_e;
   logic signed [EW-1:0] v_e;
   logic site_ok, hop_fail;

   ccsc_ram #(.WIDTH(ccsc_pkg::POT_W), .DEPTH(ccsc_pkg::PT_DEPTH)) u_pot_ram (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (pt_waddr),
      .wr_data (potential),
      .rd_addr (pt_raddr),
      .rd_data (pt_rdata)
   );

   ccsc_ram #(.WIDTH(LW), .DEPTH(ccsc_pkg::MAX_SITES)) u_lp_ram (
      .clock   (clock),
      .wr_en   (lp_we),
      .wr_addr (lp_waddr),
      .wr_data (lp_wdata),
      .rd_addr (lp_raddr),
      .rd_data (lp_rdata)
   );

   assign row_last = (NW'(row_ff) + NW'(1)) == n_ff;
   assign col_last = (NW'(col_ff) + NW'(1)) == n_ff;
   assign a_ok     = int'(site_a) < ccsc_pkg::MAX_SITES;
   assign b_ok     = int'(site_b) < ccsc_pkg::MAX_SITES;
   assign n_eval   = (int'(cfg.site_count) > ccsc_pkg::MAX_SITES) ?
                     NW'(ccsc_pkg::MAX_SITES) : NW'(cfg.site_count);
   assign chg_col  = chg_ff[col_ff];
   assign chg_row  = chg_ff[row_ff];
   assign pt_waddr = {SW'(site_a), SW'(site_b)};

   // Datapath behind the read stage
   assign lp_v   = signed'(lp_rdata);
   assign pot_x  = signed'(LW'(pt_rdata));
   always_comb begin
      unique case (s1_chg_ff)
         ccsc_pkg::CHG_POS: pot_term = pot_x;
         ccsc_pkg::CHG_NEG: pot_term = -pot_x;
         default:           pot_term = '0;
      endcase
   end
   assign lp_sum   = (s1_first_ff ? LW'(0) : acc_ff) + pot_term;
   assign lp_wdata = lp_sum;
   assign lp_waddr = s1_row_ff;

   assign v_x    = CW'(lp_v);
   assign vi_x   = CW'(vi_ff);
   assign p_x    = signed'(CW'(pt_rdata));
   assign mum_x  = CW'(cfg.mu_minus);
   assign mup_x  = CW'(cfg.mu_plus);
   assign tol_x  = signed'(CW'(cfg.tolerance));
   assign ntol_x = -tol_x;
   assign dm     = mum_x - v_x;
   assign dp     = mup_x - v_x;
   assign v_e    = EW'(lp_v);

   always_comb begin
      unique case (s1_chg_ff)
         ccsc_pkg::CHG_NEG: site_ok = dm < tol_x;
         ccsc_pkg::CHG_POS: site_ok = dp > ntol_x;
         default:           site_ok = (dm > ntol_x) && (dp < tol_x);
      endcase
   end

   assign hop_e    = (ci_ff == ccsc_pkg::CHG_NEG) ? (vi_x - v_x - p_x) : (v_x - vi_x - p_x);
   assign hop_fail = (s1_chg_ff > ci_ff) && (hop_e < ntol_x);

   assign req_ready     = state_ff == ST_IDLE;
   assign res_valid     = state_ff == ST_DONE;
   assign res.fail_kind = kind_ff;
   assign res.bad_site  = ccsc_pkg::IDX_FLD_W'(bad_ff);
   assign res.energy    = esum_ff[EW-1:1];

   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      issue_in    = issue_ff;
      acc_in      = acc_ff;
      esum_in     = esum_ff;
      kind_in     = kind_ff;
      bad_in      = bad_ff;
      ci_in       = ci_ff;
      vi_in       = vi_ff;
      s1_vld_in   = 1'b0;
      s1_first_in = col_ff == '0;
      s1_last_in  = col_last;
      s1_final_in = col_last && row_last;
      s1_row_in   = row_ff;
      s1_idx_in   = col_ff;
      s1_chg_in   = chg_col;
      pt_raddr    = {row_ff, col_ff};
      lp_raddr    = col_ff;
      pt_we       = 1'b0;
      lp_we       = 1'b0;
      chg_we      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  ccsc_pkg::REQ_WR_POT: pt_we = a_ok && b_ok;
                  ccsc_pkg::REQ_WR_CHG: chg_we = a_ok && (charge != ccsc_pkg::CHG_BAD);
                  ccsc_pkg::REQ_EVAL: begin
                     n_in    = n_eval;
                     row_in  = '0;
                     col_in  = '0;
                     kind_in = ccsc_pkg::FAIL_NONE;
                     bad_in  = '0;
                     esum_in = '0;
                     if (n_eval == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_LOCAL;
                        issue_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_LOCAL: begin
            // column walk: local(i) sums pot(j, i) * charge(j) over j
            pt_raddr = {col_ff, row_ff};
            if (issue_ff) begin
               s1_vld_in = 1'b1;
               if (col_last) begin
                  col_in = '0;
                  if (row_last) begin
                     issue_in = 1'b0;
                  end else begin
                     row_in = row_ff + SW'(1);
                  end
               end else begin
                  col_in = col_ff + SW'(1);
               end
            end
            if (s1_vld_ff) begin
               acc_in = lp_sum;
               lp_we  = s1_last_ff;
               if (s1_final_ff) begin
                  state_in = ST_SITE;
                  row_in   = '0;
                  col_in   = '0;
                  issue_in = 1'b1;
               end
            end
         end

         ST_SITE: begin
            if (issue_ff) begin
               s1_vld_in = 1'b1;
               if (col_last) begin
                  issue_in = 1'b0;
               end else begin
                  col_in = col_ff + SW'(1);
               end
            end
            if (s1_vld_ff) begin
               unique case (s1_chg_ff)
                  ccsc_pkg::CHG_POS: esum_in = esum_ff + v_e;
                  ccsc_pkg::CHG_NEG: esum_in = esum_ff - v_e;
                  default:           esum_in = esum_ff;
               endcase
               if (!site_ok && kind_ff == ccsc_pkg::FAIL_NONE) begin
                  kind_in = ccsc_pkg::FAIL_SITE;
                  bad_in  = s1_idx_ff;
               end
               if (s1_last_ff) begin
                  row_in = '0;
                  if (kind_ff != ccsc_pkg::FAIL_NONE || !site_ok) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_HSRC;
                  end
               end
            end
         end

         ST_HSRC: begin
            lp_raddr = row_ff;
            if (chg_row == ccsc_pkg::CHG_POS) begin
               if (row_last) begin
                  state_in = ST_DONE;
               end else begin
                  row_in = row_ff + SW'(1);
               end
            end else begin
               ci_in    = chg_row;
               state_in = ST_HLOAD;
            end
         end

         ST_HLOAD: begin
            vi_in    = lp_v;
            col_in   = '0;
            issue_in = 1'b1;
            state_in = ST_HOP;
         end

         ST_HOP: begin
            if (issue_ff) begin
               s1_vld_in = 1'b1;
               if (col_last) begin
                  issue_in = 1'b0;
               end else begin
                  col_in = col_ff + SW'(1);
               end
            end
            if (s1_vld_ff) begin
               if (hop_fail) begin
                  kind_in  = ccsc_pkg::FAIL_HOP;
                  bad_in   = row_ff;
                  issue_in = 1'b0;
                  state_in = ST_DONE;
               end else if (s1_last_ff) begin
                  if (row_last) begin
                     state_in = ST_DONE;
                  end else begin
                     row_in   = row_ff + SW'(1);
                     state_in = ST_HSRC;
                  end
               end
            end
         end

         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
            issue_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issue_ff  <= 1'b0;
         s1_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issue_ff  <= issue_in;
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      s1_first_ff <= s1_first_in;
      s1_last_ff  <= s1_last_in;
      s1_final_ff <= s1_final_in;
      s1_row_ff   <= s1_row_in;
      s1_idx_ff   <= s1_idx_in;
      s1_chg_ff   <= s1_chg_in;
      acc_ff      <= acc_in;
      esum_ff     <= esum_in;
      kind_ff     <= kind_in;
      bad_ff      <= bad_in;
      ci_ff       <= ci_in;
      vi_ff       <= vi_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ccsc_pkg::MAX_SITES; k++) begin
            chg_ff[k] <= ccsc_pkg::CHG_ZERO;
         end
      end else if (chg_we) begin
         chg_ff[SW'(site_a)] <= charge;
      end
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !s1_vld_ff && !issue_ff)
      else $error("read stage still busy while idle");

   a_issue_phase: assert property (@(posedge clock) disable iff (reset)
      issue_ff |-> (state_ff == ST_LOCAL || state_ff == ST_SITE || state_ff == ST_HOP))
      else $error("reads issued outside a walking phase");

   a_stable_site: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && kind_ff == ccsc_pkg::FAIL_NONE) |-> bad_ff == '0)
      else $error("stable result carries a failing site");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> (kind_ff == ccsc_pkg::FAIL_NONE ||
                               kind_ff == ccsc_pkg::FAIL_SITE ||
                               kind_ff == ccsc_pkg::FAIL_HOP))
      else $error("result carries an unknown failure kind");

endmodule

@@ rtl/charge_config_stability_checker.sv @@
// Top level: stream channels, register port and result register of the stability checker.
`timescale 1ns / 1ps

// Usage
//   req channel: one transfer per item. tuser selects the item kind (write potential,
//   write charge, evaluate). A write lands as it is taken; out-of-range indexes and
//   the charge pattern 2'b10 are dropped. An evaluate produces exactly one rsp transfer.
//   rsp channel: tuser holds the failure kind, tdata the first failing site and the
//   system energy (Q24 eV).
//   csr port: site_count, mu_minus, mu_plus, tolerance at byte offsets 0, 4, 8, 12.
//   Write only while no evaluate is in flight.
// Evaluate sequence
//   An evaluate walks the potential table through its single read port: local
//   potentials over all pairs, then site checks, then a hop walk for each source
//   site that is not +1 (a +1 source is skipped). A failing site check ends the
//   evaluate after the site checks; a failing hop ends it at once.
// Reset
//   Synchronous, active high: all charges return to zero, registers to their defaults;
//   potential entries hold garbage until written.
// Backpressure
//   The result waits in an output register; the next items are taken meanwhile, and a
//   further evaluate holds at its end until that register frees up.

module charge_config_stability_checker (
   input  logic                       clock,
   input  logic                       reset,
   // stream in
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [39:0]                req_tdata,  // site_a[4:0], site_b[9:5],
                                                  // potential[37:10], charge[39:38]
   input  logic [1:0]                 req_tuser,  // req_type[1:0]
   // stream out
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [47:0]                rsp_tdata,  // bad_site[4:0], energy[45:5], zero[47:46]
   output logic [1:0]                 rsp_tuser,  // fail_kind[1:0]
   // register port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [ccsc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [ccsc_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [ccsc_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);

   ccsc_pkg::cfg_type    cfg_ff, cfg_in;
   ccsc_pkg::result_type eng_res, rsp_res_ff;
   logic                 eng_valid, eng_ready, eng_req_ready;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic                 csr_wr;
   logic [1:0]           csr_idx;

   // Register port: no wait states
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            ccsc_pkg::REG_SITE_COUNT:
               cfg_in.site_count = csr_pwdata[ccsc_pkg::CNT_FLD_W-1:0];
            ccsc_pkg::REG_MU_MINUS:
               cfg_in.mu_minus   = signed'(csr_pwdata[ccsc_pkg::MU_W-1:0]);
            ccsc_pkg::REG_MU_PLUS:
               cfg_in.mu_plus    = signed'(csr_pwdata[ccsc_pkg::MU_W-1:0]);
            ccsc_pkg::REG_TOLERANCE:
               cfg_in.tolerance  = csr_pwdata[ccsc_pkg::TOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.site_count <= ccsc_pkg::SITE_COUNT_RST;
         cfg_ff.mu_minus   <= signed'(ccsc_pkg::MU_MINUS_RST);
         cfg_ff.mu_plus    <= signed'(ccsc_pkg::MU_PLUS_RST);
         cfg_ff.tolerance  <= ccsc_pkg::TOL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back: signed registers sign-extend
   always_comb begin
      unique case (csr_idx)
         ccsc_pkg::REG_SITE_COUNT: csr_prdata = ccsc_pkg::CSR_DW'(cfg_ff.site_count);
         ccsc_pkg::REG_MU_MINUS:   csr_prdata = ccsc_pkg::CSR_DW'(cfg_ff.mu_minus);
         ccsc_pkg::REG_MU_PLUS:    csr_prdata = ccsc_pkg::CSR_DW'(cfg_ff.mu_plus);
         ccsc_pkg::REG_TOLERANCE:  csr_prdata = ccsc_pkg::CSR_DW'(cfg_ff.tolerance);
         default:                  csr_prdata = '0;
      endcase
   end

   // Sequencer with the potential table and local potential memories
   ccsc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_ready (eng_req_ready),
      .req_kind  (req_tuser),
      .site_a    (req_tdata[4:0]),
      .site_b    (req_tdata[9:5]),
      .potential (req_tdata[37:10]),
      .charge    (signed'(req_tdata[39:38])),
      .res_valid (eng_valid),
      .res_ready (eng_ready),
      .res       (eng_res)
   );

   assign req_tready = eng_req_ready;

   // Output register: free when empty or when its transfer completes this cycle
   assign eng_ready = !rsp_vld_ff || rsp_tready;

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (eng_ready) begin
         rsp_vld_in = eng_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Hold the payload while stalled, advance on a new result
   always_ff @(posedge clock) begin
      if (eng_ready && eng_valid) begin
         rsp_res_ff <= eng_res;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_res_ff.fail_kind;
   assign rsp_tdata  = {2'b00, rsp_res_ff.energy, rsp_res_ff.bad_site};

endmodule

@@ verif/charge_config_stability_checker_tb.sv @@
// Self-checking testbench for the charge configuration stability checker.
`timescale 1ns / 1ps

module charge_config_stability_checker_tb;

   // Request code with no meaning to the block; it must be dropped silently.
   localparam logic [1:0]                REQ_UNUSED    = 2'd3;
   localparam logic [ccsc_pkg::MU_W-1:0] MU_MIN        = 29'h1000_0000;
   localparam logic [ccsc_pkg::MU_W-1:0] MU_MAX        = 29'h0FFF_FFFF;
   // Sites whose table rows and columns are written up front; every layout stays inside.
   localparam int                        TABLE_SITES   = 16;
   localparam int                        SETTLE_CYCLES = 16;
   localparam int                        LONG_HOLD     = 3000;
   // The long hold outlasts a full evaluate at 16 sites.
   localparam int                        QUIET_LIMIT   = 20000;

   typedef struct packed {
      logic [1:0]                     op;
      logic [ccsc_pkg::IDX_FLD_W-1:0] site_a;
      logic [ccsc_pkg::IDX_FLD_W-1:0] site_b;
      logic [ccsc_pkg::POT_W-1:0]     potential;
      logic [ccsc_pkg::CHG_W-1:0]     charge;
   } stab_item_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [39:0]         req_tdata = '0;   // site_a[4:0], site_b[9:5], potential[37:10],
                                          // charge[39:38]
   logic [1:0]          req_tuser = '0;   // req_type[1:0]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [47:0]         rsp_tdata;        // bad_site[4:0], energy[45:5], zero[47:46]
   logic [1:0]          rsp_tuser;        // fail_kind[1:0]
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [ccsc_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [ccsc_pkg::CSR_DW-1:0] csr_pwdata = '0;
   logic [ccsc_pkg::CSR_DW-1:0] csr_prdata;
   logic                csr_pready;

   // Mirror of the block state: potentials, charges and the four registers.
   logic [ccsc_pkg::POT_W-1:0]          pot_model [ccsc_pkg::PT_DEPTH];
   int                                  charge_model [ccsc_pkg::MAX_SITES] = '{default: 0};
   logic [ccsc_pkg::CNT_FLD_W-1:0]      sites_in_use = ccsc_pkg::SITE_COUNT_RST;
   logic signed [ccsc_pkg::MU_W-1:0]    mu_neg_level = ccsc_pkg::MU_MINUS_RST;
   logic signed [ccsc_pkg::MU_W-1:0]    mu_pos_level = ccsc_pkg::MU_PLUS_RST;
   logic [ccsc_pkg::TOL_W-1:0]          zero_tol = ccsc_pkg::TOL_RST;

   stab_item_type        items_to_send [$];
   ccsc_pkg::result_type verdicts_due [$];
   stab_item_type        item_on_bus;
   ccsc_pkg::result_type want;
   int                  mismatch_count = 0;
   int                  holds_asked = 0;
   int                  holds_served = 0;
   int                  hold_left = 0;
   int                  stretch_left = 0;
   int                  stretch_mode = 0;
   int                  burst_left = 1;
   int                  gap_left = 0;
   int                  quiet_cycles = 0;

   charge_config_stability_checker i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Work out the verdict on the current charge layout: local potentials first,
   // then per-site charge-state conditions, then single hops, and the energy last.
   function automatic ccsc_pkg::result_type judge_layout();
      ccsc_pkg::result_type verdict;
      longint     site_pot [ccsc_pkg::MAX_SITES];
      longint     tol, mum, mup, v, e, d, sum;
      int         n;
      logic       ok;
      n = (sites_in_use > ccsc_pkg::MAX_SITES) ? ccsc_pkg::MAX_SITES : int'(sites_in_use);
      tol = longint'(zero_tol);
      mum = mu_neg_level;
      mup = mu_pos_level;
      verdict.fail_kind = ccsc_pkg::FAIL_NONE;
      verdict.bad_site = '0;
      // Column i of the table carries the influence of every site on site i.
      for (int i = 0; i < n; i++) begin
         site_pot[i] = 0;
         for (int j = 0; j < n; j++)
            site_pot[i] += longint'(pot_model[j * ccsc_pkg::MAX_SITES + i]) * charge_model[j];
      end
      for (int i = 0; i < n && verdict.fail_kind == ccsc_pkg::FAIL_NONE; i++) begin
         v = site_pot[i];
         if (charge_model[i] < 0)
            ok = (mum - v) < tol;
         else if (charge_model[i] > 0)
            ok = (mup - v) > -tol;
         else
            ok = ((mum - v) > -tol) && ((mup - v) < tol);
         if (!ok) begin
            verdict.fail_kind = ccsc_pkg::FAIL_SITE;
            verdict.bad_site = ccsc_pkg::IDX_FLD_W'(i);
         end
      end
      // Hops run from a more negative source to every more positive target; the
      // first source with an energy-lowering hop is the one reported.
      for (int i = 0; i < n && verdict.fail_kind == ccsc_pkg::FAIL_NONE; i++) begin
         if (charge_model[i] <= 0) begin
            d = (charge_model[i] < 0) ? 1 : -1;
            for (int j = 0; j < n && verdict.fail_kind == ccsc_pkg::FAIL_NONE; j++) begin
               if (charge_model[j] > charge_model[i]) begin
                  e = site_pot[i] * d - site_pot[j] * d
                      - longint'(pot_model[i * ccsc_pkg::MAX_SITES + j]);
                  if (e < -tol) begin
                     verdict.fail_kind = ccsc_pkg::FAIL_HOP;
                     verdict.bad_site = ccsc_pkg::IDX_FLD_W'(i);
                  end
               end
            end
         end
      end
      sum = 0;
      for (int i = 0; i < n; i++)
         sum += site_pot[i] * charge_model[i];
      // Halve toward minus infinity, then wrap to the result width.
      verdict.energy = ccsc_pkg::ENERGY_W'(sum >>> 1);
      return verdict;
   endfunction

   // Apply one accepted transfer to the mirror; an evaluate queues its verdict.
   task automatic take_request(input stab_item_type it);
      unique case (it.op)
         ccsc_pkg::REQ_WR_POT: pot_model[{it.site_a, it.site_b}] = it.potential;
         ccsc_pkg::REQ_WR_CHG: begin
            unique case (it.charge)
               ccsc_pkg::CHG_NEG:  charge_model[it.site_a] = -1;
               ccsc_pkg::CHG_ZERO: charge_model[it.site_a] = 0;
               ccsc_pkg::CHG_POS:  charge_model[it.site_a] = 1;
               default:  ;   // pattern 2'b10 is dropped
            endcase
         end
         ccsc_pkg::REQ_EVAL: verdicts_due = {verdicts_due, judge_layout()};
         default: ;
      endcase
   endtask

   function automatic void offer(input logic [1:0] op,
                                 input logic [ccsc_pkg::IDX_FLD_W-1:0] a,
                                 input logic [ccsc_pkg::IDX_FLD_W-1:0] b,
                                 input logic [ccsc_pkg::POT_W-1:0] pot,
                                 input logic [ccsc_pkg::CHG_W-1:0] chg);
      stab_item_type it;
      it.op = op;
      it.site_a = a;
      it.site_b = b;
      it.potential = pot;
      it.charge = chg;
      items_to_send = {items_to_send, it};
   endfunction

   // Mostly small potentials so that layouts stay near the decision edges;
   // now and then a full-range value to move every bit.
   function automatic logic [ccsc_pkg::POT_W-1:0] rand_potential();
      unique case ($urandom_range(0, 31))
         0:       return ccsc_pkg::POT_W'($urandom);
         1, 2, 3: return ccsc_pkg::POT_W'($urandom_range(0, 1 << 20));
         default: return ccsc_pkg::POT_W'($urandom_range(0, 4095));
      endcase
   endfunction

   function automatic logic [ccsc_pkg::CHG_W-1:0] rand_charge();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         return ccsc_pkg::CHG_BAD;
      else if (pick < 5)
         return ccsc_pkg::CHG_ZERO;
      else if (pick < 13)
         return ccsc_pkg::CHG_NEG;
      return ccsc_pkg::CHG_POS;
   endfunction

   function automatic logic [ccsc_pkg::IDX_FLD_W-1:0] rand_site(input int focus);
      if (focus == 0 || $urandom_range(0, 9) == 0)
         return ccsc_pkg::IDX_FLD_W'($urandom);
      return ccsc_pkg::IDX_FLD_W'($urandom_range(0, focus - 1));
   endfunction

   // Random traffic: rewrite charges and potentials, mostly of the sites in use, evaluate
   // often, with a sprinkle of bad charge patterns and unused request codes.
   task automatic queue_random_items(input int count, input int focus);
      int pick;
      logic [1:0] op;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            op = ccsc_pkg::REQ_WR_CHG;
         else if (pick < 75)
            op = ccsc_pkg::REQ_WR_POT;
         else if (pick < 95)
            op = ccsc_pkg::REQ_EVAL;
         else
            op = REQ_UNUSED;
         offer(op, rand_site(focus), rand_site(focus), rand_potential(), rand_charge());
      end
   endtask

   // Register write: setup phase, access phase, then an idle wait so that
   // back-to-back writes never assign the same signal twice in one step.
   task automatic write_csr(input logic [1:0] idx, input logic [ccsc_pkg::CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // The register takes the value at this edge.
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      unique case (idx)
         ccsc_pkg::REG_SITE_COUNT: sites_in_use = value[ccsc_pkg::CNT_FLD_W-1:0];
         ccsc_pkg::REG_MU_MINUS:   mu_neg_level = value[ccsc_pkg::MU_W-1:0];
         ccsc_pkg::REG_MU_PLUS:    mu_pos_level = value[ccsc_pkg::MU_W-1:0];
         ccsc_pkg::REG_TOLERANCE:  zero_tol = value[ccsc_pkg::TOL_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_layout_rules(input logic [ccsc_pkg::CNT_FLD_W-1:0] count,
                                   input logic [ccsc_pkg::MU_W-1:0] neg_mu,
                                   input logic [ccsc_pkg::MU_W-1:0] pos_mu,
                                   input logic [ccsc_pkg::TOL_W-1:0] tol);
      write_csr(ccsc_pkg::REG_SITE_COUNT, ccsc_pkg::CSR_DW'(count));
      write_csr(ccsc_pkg::REG_MU_MINUS,
                {{(ccsc_pkg::CSR_DW - ccsc_pkg::MU_W){neg_mu[ccsc_pkg::MU_W-1]}}, neg_mu});
      write_csr(ccsc_pkg::REG_MU_PLUS,
                {{(ccsc_pkg::CSR_DW - ccsc_pkg::MU_W){pos_mu[ccsc_pkg::MU_W-1]}}, pos_mu});
      write_csr(ccsc_pkg::REG_TOLERANCE, ccsc_pkg::CSR_DW'(tol));
   endtask

   // Hold until every item is sent and every verdict has come back, then let
   // the block finish any trailing write before registers change.
   task automatic wait_quiet();
      while (items_to_send.size() != 0 || req_tvalid || verdicts_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [ccsc_pkg::CNT_FLD_W-1:0] count,
                            input logic [ccsc_pkg::MU_W-1:0] neg_mu,
                            input logic [ccsc_pkg::MU_W-1:0] pos_mu,
                            input logic [ccsc_pkg::TOL_W-1:0] tol,
                            input int items, input logic long_hold);
      set_layout_rules(count, neg_mu, pos_mu, tol);
      if (long_hold)
         holds_asked++;
      queue_random_items(items, (count > TABLE_SITES) ? TABLE_SITES : int'(count));
      wait_quiet();
   endtask

   // Driver: pop the next item when the bus is free or the current transfer
   // completes; work in bursts with random gaps, some bursts long and unbroken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready)
            take_request(item_on_bus);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || items_to_send.size() == 0) begin
               if (gap_left > 0)
                  gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               item_on_bus = items_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {item_on_bus.charge, item_on_bus.potential,
                             item_on_bus.site_b, item_on_bus.site_a};
               req_tuser <= item_on_bus.op;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                           : $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // Receiver: serve a long hold when one is asked for, otherwise stall on
   // stretches of always-ready, coin-flip and mostly-stalled behavior.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         stretch_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         if (stretch_left == 0) begin
            stretch_mode = $urandom_range(0, 2);
            stretch_left = $urandom_range(1, 64);
         end
         stretch_left--;
         unique case (stretch_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Monitor: check each result transfer against the oldest verdict.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected result, fail_kind %0d bad_site %0d energy %0d", $time,
                     rsp_tuser, rsp_tdata[4:0], $signed(rsp_tdata[45:5]));
            mismatch_count++;
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_tuser !== want.fail_kind) begin
               $display("%0t: fail_kind expected %0d actual %0d", $time, want.fail_kind,
                        rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata[4:0] !== want.bad_site) begin
               $display("%0t: bad_site expected %0d actual %0d", $time, want.bad_site,
                        rsp_tdata[4:0]);
               mismatch_count++;
            end
            if (rsp_tdata[45:5] !== want.energy) begin
               $display("%0t: energy expected %0d actual %0d", $time, want.energy,
                        $signed(rsp_tdata[45:5]));
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: drop the run when no transfer moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Keep every layout within the written corner of the table.
      write_csr(ccsc_pkg::REG_SITE_COUNT, ccsc_pkg::CSR_DW'(TABLE_SITES));

      // Write the corner once so that no evaluate reads an unwritten entry.
      for (int r = 0; r < TABLE_SITES; r++)
         for (int c = 0; c < TABLE_SITES; c++)
            offer(ccsc_pkg::REQ_WR_POT, ccsc_pkg::IDX_FLD_W'(r), ccsc_pkg::IDX_FLD_W'(c),
                  ccsc_pkg::POT_W'($urandom_range(0, 4095)), ccsc_pkg::CHG_ZERO);

      // Reset chemical potentials and tolerance: all charges neutral, so site 0 fails.
      offer(ccsc_pkg::REQ_EVAL, 0, 0, 0, ccsc_pkg::CHG_ZERO);
      // Drop the bad charge pattern and the unused request code.
      offer(ccsc_pkg::REQ_WR_CHG, 3, 0, 0, ccsc_pkg::CHG_BAD);
      offer(REQ_UNUSED, 31, 31, {ccsc_pkg::POT_W{1'b1}}, ccsc_pkg::CHG_NEG);
      offer(ccsc_pkg::REQ_WR_CHG, 0, 0, 0, ccsc_pkg::CHG_NEG);
      offer(ccsc_pkg::REQ_WR_CHG, 15, 0, 0, ccsc_pkg::CHG_POS);
      offer(ccsc_pkg::REQ_WR_CHG, 7, 0, 0, ccsc_pkg::CHG_NEG);
      // Largest potential off the diagonal and on it.
      offer(ccsc_pkg::REQ_WR_POT, 15, 0, {ccsc_pkg::POT_W{1'b1}}, ccsc_pkg::CHG_ZERO);
      offer(ccsc_pkg::REQ_WR_POT, 7, 7, {ccsc_pkg::POT_W{1'b1}}, ccsc_pkg::CHG_ZERO);
      offer(ccsc_pkg::REQ_EVAL, 0, 0, 0, ccsc_pkg::CHG_ZERO);
      wait_quiet();

      // Two sites, -1 then +1, with wide-open chemical potentials and zero tolerance:
      // a hop that lowers the energy, then the same layout made stable.
      set_layout_rules(2, MU_MIN, MU_MAX, 0);
      offer(ccsc_pkg::REQ_WR_POT, 0, 0, 0, ccsc_pkg::CHG_ZERO);
      offer(ccsc_pkg::REQ_WR_POT, 1, 0, 0, ccsc_pkg::CHG_ZERO);
      offer(ccsc_pkg::REQ_WR_POT, 0, 1, 0, ccsc_pkg::CHG_ZERO);
      offer(ccsc_pkg::REQ_WR_POT, 1, 1, 100, ccsc_pkg::CHG_ZERO);
      offer(ccsc_pkg::REQ_WR_CHG, 0, 0, 0, ccsc_pkg::CHG_NEG);
      offer(ccsc_pkg::REQ_WR_CHG, 1, 0, 0, ccsc_pkg::CHG_POS);
      offer(ccsc_pkg::REQ_EVAL, 0, 0, 0, ccsc_pkg::CHG_ZERO);
      offer(ccsc_pkg::REQ_WR_POT, 1, 1, 0, ccsc_pkg::CHG_ZERO);
      offer(ccsc_pkg::REQ_EVAL, 0, 0, 0, ccsc_pkg::CHG_ZERO);
      wait_quiet();

      // No sites in use: stable with zero energy.
      write_csr(ccsc_pkg::REG_SITE_COUNT, 0);
      offer(ccsc_pkg::REQ_EVAL, 0, 0, 0, ccsc_pkg::CHG_ZERO);
      wait_quiet();

      // Random phases; each boundary also pauses the sender until all verdicts are in.
      run_phase(16, MU_MIN, MU_MAX, 0, 40, 1'b0);
      run_phase(5, MU_MIN, MU_MAX, {ccsc_pkg::TOL_W{1'b1}}, 40, 1'b1);
      run_phase(1, ccsc_pkg::MU_MINUS_RST, ccsc_pkg::MU_PLUS_RST, ccsc_pkg::TOL_RST, 25, 1'b0);
      run_phase(0, ccsc_pkg::MU_W'($urandom), ccsc_pkg::MU_W'($urandom),
                ccsc_pkg::TOL_W'($urandom), 15, 1'b0);
      run_phase(16, MU_MAX, MU_MIN, ccsc_pkg::TOL_W'($urandom), 30, 1'b0);
      run_phase(8, ccsc_pkg::MU_W'($urandom), ccsc_pkg::MU_W'($urandom),
                ccsc_pkg::TOL_W'($urandom), 30, 1'b0);
      run_phase(3, MU_MIN, MU_MAX, 100, 30, 1'b0);
      run_phase(16, MU_MIN, MU_MAX, 1000, 30, 1'b0);
      run_phase(2, MU_MIN, MU_MAX, 0, 20, 1'b0);
      run_phase(12, ccsc_pkg::MU_MINUS_RST, ccsc_pkg::MU_PLUS_RST, 0, 20, 1'b0);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
